>>> rtl/core/pft_pkg.sv
// shared types and constants of the polygon fan triangulator
package pft_pkg;

  localparam int MAX_FACE_VERTICES_DEF = 256;

  localparam int VERTEX_W = 32;
  localparam int FACE_SIZE_W = 9;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W = 1;

  typedef enum logic [1:0] {
    KIND_TRIANGLE = 2'd0,
    KIND_LINE     = 2'd1,
    KIND_POINT    = 2'd2
  } prim_kind_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_FLIP_WINDING     = 2'd0,
    CFG_ENABLE_TRIANGLES = 2'd1,
    CFG_ENABLE_LINES     = 2'd2,
    CFG_ENABLE_POINTS    = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic [VERTEX_W-1:0]    vtx_index;
    logic [FACE_SIZE_W-1:0] face_size;
  } in_req_t;

  typedef struct packed {
    logic [VERTEX_W-1:0] index_a;
    logic [VERTEX_W-1:0] index_b;
    logic [VERTEX_W-1:0] index_c;
    prim_kind_t          prim_kind;
  } out_req_t;

  typedef struct packed {
    logic flip_winding;
    logic enable_triangles;
    logic enable_lines;
    logic enable_points;
  } cfg_t;

  typedef struct packed {
    logic     valid;
    out_req_t req;
  } result_t;

endpackage

>>> rtl/core/pft_cfg_regs.sv
// configuration registers of the polygon fan triangulator
module pft_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [pft_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [pft_pkg::CFG_DATA_W-1:0]   cfg_data,
  output pft_pkg::cfg_t                    cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.flip_winding     <= 1'b0;
      cfg.enable_triangles <= 1'b1;
      cfg.enable_lines     <= 1'b1;
      cfg.enable_points    <= 1'b1;
    end else if (cfg_write) begin
      unique case (pft_pkg::cfg_index_t'(cfg_index))
        pft_pkg::CFG_FLIP_WINDING:     cfg.flip_winding     <= cfg_data[0];
        pft_pkg::CFG_ENABLE_TRIANGLES: cfg.enable_triangles <= cfg_data[0];
        pft_pkg::CFG_ENABLE_LINES:     cfg.enable_lines     <= cfg_data[0];
        pft_pkg::CFG_ENABLE_POINTS:    cfg.enable_points    <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/core/pft_assembler.sv
// face tracking state and primitive assembly logic
module pft_assembler #(
  parameter int MAX_FACE_VERTICES = pft_pkg::MAX_FACE_VERTICES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  pft_pkg::in_req_t in_req,
  input  pft_pkg::cfg_t    cfg,
  output pft_pkg::result_t result
);

  localparam int PW = $clog2(MAX_FACE_VERTICES);
  localparam int SW_MIN = $clog2(MAX_FACE_VERTICES + 1);
  localparam int SW = (SW_MIN > pft_pkg::FACE_SIZE_W) ? SW_MIN : pft_pkg::FACE_SIZE_W;
  localparam logic [SW-1:0] MAX_W = SW'(MAX_FACE_VERTICES);
  localparam logic [SW-1:0] ONE_W = SW'(1);
  localparam logic [SW-1:0] TWO_W = SW'(2);
  localparam logic [SW-1:0] THREE_W = SW'(3);

  logic [PW-1:0]                corner_position;
  logic [PW-1:0]                corner_position_next;
  logic [pft_pkg::VERTEX_W-1:0] apex_index;
  logic [pft_pkg::VERTEX_W-1:0] previous_index;
  logic [pft_pkg::VERTEX_W-1:0] apex_cur;
  logic [pft_pkg::VERTEX_W-1:0] vtx;
  logic [SW-1:0]                size_raw;
  logic [SW-1:0]                size;
  logic [SW-1:0]                pos_w;
  logic [SW-1:0]                pos_inc;

  always_comb begin
    vtx = in_req.vtx_index;
    size_raw = SW'(in_req.face_size);
    // zero counts as a one-corner face, oversize saturates
    priority if (size_raw == '0) begin
      size = ONE_W;
    end else if (size_raw > MAX_W) begin
      size = MAX_W;
    end else begin
      size = size_raw;
    end
    pos_w = SW'(corner_position);
    pos_inc = pos_w + ONE_W;
    apex_cur = (corner_position == '0) ? vtx : apex_index;
    corner_position_next = (pos_inc >= size) ? '0 : pos_inc[PW-1:0];

    result.valid = 1'b0;
    result.req.index_a = vtx;
    result.req.index_b = '0;
    result.req.index_c = '0;
    result.req.prim_kind = pft_pkg::KIND_POINT;
    priority if (size >= THREE_W) begin
      result.valid = (pos_w >= TWO_W) && cfg.enable_triangles;
      result.req.index_a = apex_cur;
      result.req.index_b = cfg.flip_winding ? vtx : previous_index;
      result.req.index_c = cfg.flip_winding ? previous_index : vtx;
      result.req.prim_kind = pft_pkg::KIND_TRIANGLE;
    end else if (size == TWO_W) begin
      result.valid = (pos_w >= ONE_W) && cfg.enable_lines;
      result.req.index_a = previous_index;
      result.req.index_b = vtx;
      result.req.prim_kind = pft_pkg::KIND_LINE;
    end else begin
      result.valid = cfg.enable_points;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      corner_position <= '0;
      apex_index <= '0;
      previous_index <= '0;
    end else if (accept) begin
      corner_position <= corner_position_next;
      apex_index <= apex_cur;
      previous_index <= vtx;
    end
  end

endmodule

>>> rtl/core/pft_out_buffer.sv
// output register with skid entry
module pft_out_buffer (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  pft_pkg::out_req_t load_req,
  output logic              full,
  output logic              out_valid,
  input  logic              out_stall,
  output pft_pkg::out_req_t out_req
);

  logic              skid_valid;
  pft_pkg::out_req_t skid_req;
  logic              take;

  assign take = out_valid && !out_stall;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      priority if (skid_valid) begin
        if (take) begin
          skid_valid <= 1'b0;
        end
      end else if (load) begin
        if (out_valid && !take) begin
          skid_valid <= 1'b1;
        end else begin
          out_valid <= 1'b1;
        end
      end else if (take) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid && take) begin
      out_req <= skid_req;
    end else if (!skid_valid && load && (!out_valid || take)) begin
      out_req <= load_req;
    end
    if (!skid_valid && load && out_valid && !take) begin
      skid_req <= load_req;
    end
  end

endmodule

>>> rtl/core/polygon_fan_triangulator.sv
// top level of the polygon fan triangulator
// takes one vertex index request per cycle while in_stall is low and emits at
// most one primitive per request: a fan triangle from the third corner of a
// face on, a line on the second corner of a two-corner face, a point for a
// one-corner face. an accepted request is assembled in the same cycle and its
// primitive lands in the output register, or in the skid entry if a primitive
// waits there untaken. a one-entry skid buffer behind the output register lets
// a request be taken while a primitive waits; in_stall rises only once both
// entries hold primitives. requests of a disabled kind still advance the face
// state and produce nothing. configuration is written through a plain write
// port, by the user only while the block is idle; the block does not enforce it
module polygon_fan_triangulator #(
  parameter int MAX_FACE_VERTICES = pft_pkg::MAX_FACE_VERTICES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // vertex request channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  pft_pkg::in_req_t                 in_req,
  // primitive request channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output pft_pkg::out_req_t                out_req,
  // configuration write port
  input  logic                             cfg_write,
  input  logic [pft_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [pft_pkg::CFG_DATA_W-1:0]   cfg_data
);

  pft_pkg::cfg_t    cfg;
  pft_pkg::result_t result;
  logic             accept;
  logic             buf_full;

  // a request is taken whenever the skid entry is free
  assign in_stall = buf_full;
  assign accept = in_valid && !buf_full;

  pft_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // face state and primitive selection
  pft_assembler #(
    .MAX_FACE_VERTICES (MAX_FACE_VERTICES)
  ) u_asm (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .in_req (in_req),
    .cfg    (cfg),
    .result (result)
  );

  // only requests that yield a primitive load the output side
  pft_out_buffer u_obuf (
    .clk       (clk),
    .rst       (rst),
    .load      (accept && result.valid),
    .load_req  (result.req),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_req   (out_req)
  );

endmodule
